@@ hdl/dct_pkg.sv @@
`timescale 1ns / 1ps
package dct_pkg;

  localparam logic [1:0] OP_SCAN   = 2'd0;
  localparam logic [1:0] OP_EDGE   = 2'd1;
  localparam logic [1:0] OP_ACCEPT = 2'd2;
  localparam logic [1:0] OP_COUNT  = 2'd3;

  localparam logic KIND_TOKEN = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_ASCII_MAX = 8'd127;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0a;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_EOL = 8'h00;

  localparam int NUM_CLASSES = 9;
  localparam logic [15:0] LEN_MAX = 16'hffff;

  typedef logic [NUM_CLASSES-1:0] class_vec_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [7:0]        character;
    logic [7:0]        state_index;
    logic [3:0]        edge_slot;
    logic [7:0]        target_state;
    logic signed [7:0] edge_label;
    logic [7:0]        token_id;
    logic [4:0]        edge_count;
    class_vec_t        cls;
  } item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  found_id;
    logic [15:0] token_length;
    logic        last;
  } result_t;

  // bit k-1 set when the byte belongs to class label -k
  function automatic class_vec_t classify(input logic [7:0] c);
    logic q;
    logic lo;
    logic up;
    logic dg;
    class_vec_t v;
    q  = (c == CH_DQUOTE) || (c == CH_SQUOTE);
    lo = (c >= CH_LOWER_A) && (c <= CH_LOWER_Z);
    up = (c >= CH_UPPER_A) && (c <= CH_UPPER_Z);
    dg = (c >= CH_DIGIT_0) && (c <= CH_DIGIT_9);
    v[0] = (c != CH_EOL) && (c <= CH_ASCII_MAX);
    v[1] = lo;
    v[2] = up;
    v[3] = lo || up;
    v[4] = dg;
    v[5] = lo || up || dg;
    v[6] = (c == CH_SPACE);
    v[7] = (c == CH_NEWLINE);
    v[8] = (c == CH_TAB);
    return q ? '0 : v;
  endfunction

  function automatic logic label_match(input logic [7:0] c, input class_vec_t cls,
                                       input logic [7:0] lbl);
    logic [7:0] code;
    logic m;
    code = ~lbl + 8'd1;
    if (!lbl[7]) begin
      m = (c == lbl);
    end else if (code >= 8'd1 && code <= 8'(NUM_CLASSES)) begin
      m = cls[4'(code - 8'd1)];
    end else begin
      m = 1'b0;
    end
    return m;
  endfunction

endpackage

@@ hdl/dfa_char_class_tokenizer.sv @@
`timescale 1ns / 1ps
// Scan transaction: look, count, then edge states trying its edges in slot order from the
// edge memory's single read port; a token followed by reprocess repeats them, and results
// are emitted while the result queue is not full. Results can be popped in the cycle
// after the engine pushes them. Throughput: one transaction per engine pass.
// Reset (rst, synchronous) clears scan state, then a pass over all NUM_STATES states
// zeroes edge counts and accept ids; full stays high during that pass.
module dfa_char_class_tokenizer #(
  parameter int NUM_STATES = 256,
  parameter int MAX_EDGES  = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        operation,
  input  logic [7:0]        character,
  input  logic [7:0]        state_index,
  input  logic [3:0]        edge_slot,
  input  logic [7:0]        target_state,
  input  logic signed [7:0] edge_label,
  input  logic [7:0]        token_id,
  input  logic [4:0]        edge_count,
  output logic              empty,
  input  logic              pop,
  output logic              kind,
  output logic [7:0]        found_id,
  output logic [15:0]       token_length,
  output logic              last
);

  logic             f_full;
  logic             f_empty;
  logic             f_pop;
  logic             busy;
  dct_pkg::item_t   f_item;
  logic             r_full;
  logic             r_push;
  dct_pkg::result_t r_in;
  dct_pkg::result_t r_out;

  assign full = f_full || busy;

  dct_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push && !full),
    .operation    (operation),
    .character    (character),
    .state_index  (state_index),
    .edge_slot    (edge_slot),
    .target_state (target_state),
    .edge_label   (edge_label),
    .token_id     (token_id),
    .edge_count   (edge_count),
    .full         (f_full),
    .pop          (f_pop),
    .empty        (f_empty),
    .item         (f_item)
  );

  dct_engine #(
    .NUM_STATES (NUM_STATES),
    .MAX_EDGES  (MAX_EDGES)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .in_empty (f_empty),
    .in_item  (f_item),
    .in_pop   (f_pop),
    .busy     (busy),
    .res_full (r_full),
    .res_push (r_push),
    .res_out  (r_in)
  );

  dct_res_queue u_res_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (r_push),
    .res_in  (r_in),
    .full    (r_full),
    .pop     (pop),
    .empty   (empty),
    .res_out (r_out)
  );

  assign kind         = r_out.kind;
  assign found_id     = r_out.found_id;
  assign token_length = r_out.token_length;
  assign last         = r_out.last;

endmodule

@@ hdl/dct_front.sv @@
`timescale 1ns / 1ps
module dct_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  logic [1:0]     operation,
  input  logic [7:0]     character,
  input  logic [7:0]     state_index,
  input  logic [3:0]     edge_slot,
  input  logic [7:0]     target_state,
  input  logic signed [7:0] edge_label,
  input  logic [7:0]     token_id,
  input  logic [4:0]     edge_count,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output dct_pkg::item_t item
);

  dct_pkg::item_t q [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       do_push;
  logic       do_pop;
  dct_pkg::item_t in_item;

  always_comb begin
    in_item.op           = operation;
    in_item.character    = character;
    in_item.state_index  = state_index;
    in_item.edge_slot    = edge_slot;
    in_item.target_state = target_state;
    in_item.edge_label   = edge_label;
    in_item.token_id     = token_id;
    in_item.edge_count   = edge_count;
    in_item.cls          = dct_pkg::classify(character);
  end

  assign full    = (cnt == 2'd2);
  assign empty   = (cnt == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign item    = q[rp];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wp] <= in_item;
    end
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) begin
        wp <= ~wp;
      end
      if (do_pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

@@ hdl/dct_res_queue.sv @@
`timescale 1ns / 1ps
module dct_res_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  dct_pkg::result_t res_in,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output dct_pkg::result_t res_out
);

  dct_pkg::result_t q [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       do_push;
  logic       do_pop;

  assign full    = (cnt == 2'd2);
  assign empty   = (cnt == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign res_out = q[rp];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wp] <= res_in;
    end
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) begin
        wp <= ~wp;
      end
      if (do_pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

@@ hdl/dct_engine.sv @@
`timescale 1ns / 1ps
module dct_engine #(
  parameter int NUM_STATES = 256,
  parameter int MAX_EDGES  = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_empty,
  input  dct_pkg::item_t   in_item,
  output logic             in_pop,
  output logic             busy,
  input  logic             res_full,
  output logic             res_push,
  output dct_pkg::result_t res_out
);

  localparam int SW = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
  localparam int CW = $clog2(MAX_EDGES + 1);
  localparam int NE = NUM_STATES * MAX_EDGES;
  localparam int AW = (NE > 1) ? $clog2(NE) : 1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_LOOK = 7'b0000010,
    S_CNT  = 7'b0000100,
    S_EDGE = 7'b0001000,
    S_ACC  = 7'b0010000,
    S_FAIL = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_t;

  state_t         state, state_next;
  logic [SW-1:0]  cur_state, cur_state_next;
  logic [7:0]     pending, pending_next;
  logic [15:0]    consumed, consumed_next;
  logic           dropping, dropping_next;
  dct_pkg::item_t item, item_next;
  logic [CW-1:0]  cnt, cnt_next;
  logic [CW-1:0]  slot, slot_next;
  logic [1:0]     nres, nres_next;
  logic           eidx, eidx_next;
  dct_pkg::result_t res0, res0_next, res1, res1_next, new_res;
  logic           clearing;
  logic [SW-1:0]  clr_idx;

  logic [15:0]    edge_mem [NE];
  logic [CW-1:0]  cnt_mem [NUM_STATES];
  logic [7:0]     acc_mem [NUM_STATES];
  logic [15:0]    edge_rd;
  logic [CW-1:0]  cnt_rd;
  logic [7:0]     acc_rd;

  logic           edge_we, cnt_we, acc_we;
  logic [AW-1:0]  edge_wa, edge_ra;
  logic [SW-1:0]  st_wa, acc_ra;
  logic [CW-1:0]  cnt_wd;
  logic [7:0]     acc_wd;
  logic [CW-1:0]  slot_rd;
  logic           st_ok, slot_ok, hit, add_res;
  logic [7:0]     e_tgt;

  assign busy  = clearing;
  assign e_tgt = edge_rd[15:8];
  assign hit   = (32'(e_tgt) < NUM_STATES) &&
                 dct_pkg::label_match(item.character, item.cls, edge_rd[7:0]);
  assign st_ok   = 32'(in_item.state_index) < NUM_STATES;
  assign slot_ok = 32'(in_item.edge_slot) < MAX_EDGES;
  assign slot_rd = (state == S_EDGE) ? slot + CW'(1) : '0;
  assign edge_ra = AW'(32'(cur_state) * MAX_EDGES + 32'(slot_rd));
  assign edge_wa = AW'(32'(in_item.state_index) * MAX_EDGES + 32'(in_item.edge_slot));
  assign acc_ra  = SW'(32'(e_tgt));

  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[edge_wa] <= {in_item.target_state, in_item.edge_label};
    end
    edge_rd <= edge_mem[edge_ra];
    if (cnt_we) begin
      cnt_mem[st_wa] <= cnt_wd;
    end
    cnt_rd <= cnt_mem[cur_state];
    if (acc_we) begin
      acc_mem[st_wa] <= acc_wd;
    end
    acc_rd <= acc_mem[acc_ra];
  end

  always_comb begin
    state_next     = state;
    cur_state_next = cur_state;
    pending_next   = pending;
    consumed_next  = consumed;
    dropping_next  = dropping;
    item_next      = item;
    cnt_next       = cnt;
    slot_next      = slot;
    nres_next      = nres;
    eidx_next      = eidx;
    res0_next      = res0;
    res1_next      = res1;
    in_pop         = 1'b0;
    res_push       = 1'b0;
    res_out        = eidx ? res1 : res0;
    res_out.last   = eidx || (nres == 2'd1);
    edge_we        = 1'b0;
    cnt_we         = 1'b0;
    acc_we         = 1'b0;
    st_wa          = SW'(32'(in_item.state_index));
    cnt_wd         = (32'(in_item.edge_count) > MAX_EDGES) ? CW'(MAX_EDGES)
                                                          : CW'(in_item.edge_count);
    acc_wd         = in_item.token_id;
    add_res        = 1'b0;
    new_res        = '0;

    if (clearing) begin
      cnt_we = 1'b1;
      acc_we = 1'b1;
      st_wa  = clr_idx;
      cnt_wd = '0;
      acc_wd = '0;
    end

    case (state)
      S_IDLE: begin
        if (!clearing && !in_empty) begin
          in_pop    = 1'b1;
          item_next = in_item;
          case (in_item.op)
            dct_pkg::OP_SCAN: begin
              if (dropping) begin
                if (in_item.character == dct_pkg::CH_EOL) begin
                  dropping_next  = 1'b0;
                  cur_state_next = '0;
                  pending_next   = '0;
                  consumed_next  = '0;
                end
              end else if (in_item.character == dct_pkg::CH_EOL) begin
                state_next = S_FAIL;
              end else begin
                state_next = S_LOOK;
              end
            end
            dct_pkg::OP_EDGE: begin
              edge_we = st_ok && slot_ok;
            end
            dct_pkg::OP_ACCEPT: begin
              acc_we = st_ok;
            end
            dct_pkg::OP_COUNT: begin
              cnt_we = st_ok;
            end
            default: begin
            end
          endcase
        end
      end
      S_LOOK: begin
        state_next = S_CNT;
      end
      S_CNT: begin
        cnt_next  = cnt_rd;
        slot_next = '0;
        state_next = (cnt_rd == '0) ? S_FAIL : S_EDGE;
      end
      S_EDGE: begin
        if (hit) begin
          cur_state_next = SW'(32'(e_tgt));
          if (consumed != dct_pkg::LEN_MAX) begin
            consumed_next = consumed + 16'd1;
          end
          state_next = S_ACC;
        end else if (slot + CW'(1) < cnt) begin
          slot_next = slot + CW'(1);
        end else begin
          state_next = S_FAIL;
        end
      end
      S_ACC: begin
        if (acc_rd != 8'd0) begin
          pending_next = acc_rd;
        end
        state_next = (nres != 2'd0) ? S_EMIT : S_IDLE;
      end
      S_FAIL: begin
        cur_state_next = '0;
        pending_next   = '0;
        consumed_next  = '0;
        if (consumed == 16'd0) begin
          if (item.character != dct_pkg::CH_EOL) begin
            add_res          = 1'b1;
            new_res.kind     = dct_pkg::KIND_ERROR;
            dropping_next    = 1'b1;
          end
          state_next = (nres != 2'd0 || add_res) ? S_EMIT : S_IDLE;
        end else if (pending != 8'd0) begin
          add_res              = 1'b1;
          new_res.kind         = dct_pkg::KIND_TOKEN;
          new_res.found_id     = pending;
          new_res.token_length = consumed;
          state_next = (item.character == dct_pkg::CH_EOL) ? S_EMIT : S_LOOK;
        end else begin
          add_res              = 1'b1;
          new_res.kind         = dct_pkg::KIND_ERROR;
          new_res.token_length = consumed;
          dropping_next = (item.character != dct_pkg::CH_EOL);
          state_next    = S_EMIT;
        end
        if (add_res) begin
          if (nres == 2'd0) begin
            res0_next = new_res;
          end else begin
            res1_next = new_res;
          end
          nres_next = nres + 2'd1;
        end
      end
      S_EMIT: begin
        if (!res_full) begin
          res_push = 1'b1;
          if (res_out.last) begin
            nres_next  = 2'd0;
            eidx_next  = 1'b0;
            state_next = S_IDLE;
          end else begin
            eidx_next = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    item <= item_next;
    cnt  <= cnt_next;
    slot <= slot_next;
    res0 <= res0_next;
    res1 <= res1_next;
    if (rst) begin
      state     <= S_IDLE;
      cur_state <= '0;
      pending   <= '0;
      consumed  <= '0;
      dropping  <= 1'b0;
      nres      <= 2'd0;
      eidx      <= 1'b0;
      clearing  <= 1'b1;
      clr_idx   <= '0;
    end else begin
      state     <= state_next;
      cur_state <= cur_state_next;
      pending   <= pending_next;
      consumed  <= consumed_next;
      dropping  <= dropping_next;
      nres      <= nres_next;
      eidx      <= eidx_next;
      if (clearing) begin
        if (clr_idx == SW'(NUM_STATES - 1)) begin
          clearing <= 1'b0;
        end else begin
          clr_idx <= clr_idx + SW'(1);
        end
      end
    end
  end

  a_push_in_emit: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (state == S_EMIT && nres != 2'd0))
    else $error("result pushed outside emit");
  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_pop)
    else $error("item taken during clearing pass");
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_EDGE) |-> (slot < cnt && cnt != '0))
    else $error("edge slot beyond edge count");
  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    (res_push && res_out.last && !res_full) |=> (nres == 2'd0 && state == S_IDLE))
    else $error("results left after last");

endmodule

@@ tb/dfa_char_class_tokenizer_tb.sv @@
`timescale 1ns / 1ps
module dfa_char_class_tokenizer_tb;

  localparam int NST = 256;
  localparam int NEDGE = 16;
  localparam int LIMIT = 3000000;

  logic clk = 0;
  logic rst = 1;
  logic push = 0;
  logic full;
  logic [1:0] operation = dct_pkg::OP_SCAN;
  logic [7:0] character = 0;
  logic [7:0] state_index = 0;
  logic [3:0] edge_slot = 0;
  logic [7:0] target_state = 0;
  logic signed [7:0] edge_label = 0;
  logic [7:0] token_id = 0;
  logic [4:0] edge_count = 0;
  logic empty;
  logic pop = 0;
  logic kind;
  logic [7:0] found_id;
  logic [15:0] token_length;
  logic last;

  dfa_char_class_tokenizer uut (.*);

  always #10 clk = ~clk;

  // predictor state
  logic [7:0] lex_tgt[NST*NEDGE];
  logic [7:0] lex_lbl[NST*NEDGE];
  bit written[NST*NEDGE];
  logic [4:0] lex_cnt[NST];
  logic [7:0] lex_acc[NST];
  logic [7:0] cur_st;
  logic [7:0] pend_id;
  logic [15:0] used_len;
  bit dropping;

  dct_pkg::result_t tokens_due[$];
  int errors = 0;
  int n_results = 0;
  int n_tokens = 0;
  int n_lexerr = 0;
  int n_items = 0;
  int cycles = 0;
  int send_idle = 21;
  int recv_idle = 49;

  function automatic bit class_hit(logic [7:0] c, logic [7:0] lbl);
    bit lo, up, dg;
    lo = c >= dct_pkg::CH_LOWER_A && c <= dct_pkg::CH_LOWER_Z;
    up = c >= dct_pkg::CH_UPPER_A && c <= dct_pkg::CH_UPPER_Z;
    dg = c >= dct_pkg::CH_DIGIT_0 && c <= dct_pkg::CH_DIGIT_9;
    if (!lbl[7]) return c == lbl;
    if (c == dct_pkg::CH_DQUOTE || c == dct_pkg::CH_SQUOTE) return 0;
    case (9'd256 - lbl)
      1: return c >= 1 && c <= 127;
      2: return lo;
      3: return up;
      4: return lo || up;
      5: return dg;
      6: return lo || up || dg;
      7: return c == dct_pkg::CH_SPACE;
      8: return c == dct_pkg::CH_NEWLINE;
      9: return c == dct_pkg::CH_TAB;
      default: return 0;
    endcase
  endfunction

  task automatic restart_token();
    cur_st = 0;
    pend_id = 0;
    used_len = 0;
  endtask

  task automatic add_result(logic k, logic [7:0] id, logic [15:0] len);
    dct_pkg::result_t r;
    r.kind = k;
    r.found_id = id;
    r.token_length = len;
    r.last = 0;
    tokens_due.push_back(r);
  endtask

  task automatic lex_char(logic [7:0] c);
    int base;
    int at;
    bit hit;
    base = tokens_due.size();
    if (dropping) begin
      if (c == dct_pkg::CH_EOL) begin
        dropping = 0;
        restart_token();
      end
      return;
    end
    for (int pass = 0; pass < 2; pass++) begin
      hit = 0;
      if (c != dct_pkg::CH_EOL) begin
        for (int s = 0; s < lex_cnt[cur_st] && !hit; s++) begin
          at = cur_st * NEDGE + s;
          if (class_hit(c, lex_lbl[at])) begin
            hit = 1;
            cur_st = lex_tgt[at];
            if (used_len != 16'hffff) used_len++;
            if (lex_acc[cur_st] != 0) pend_id = lex_acc[cur_st];
          end
        end
      end
      if (hit) break;
      if (used_len == 0) begin
        if (c != dct_pkg::CH_EOL) begin
          add_result(dct_pkg::KIND_ERROR, 8'd0, 16'd0);
          dropping = 1;
        end
        restart_token();
        break;
      end
      if (pend_id != 0) begin
        add_result(dct_pkg::KIND_TOKEN, pend_id, used_len);
        restart_token();
        continue;
      end
      add_result(dct_pkg::KIND_ERROR, 8'd0, used_len);
      restart_token();
      if (c != dct_pkg::CH_EOL) dropping = 1;
      break;
    end
    if (tokens_due.size() > base) tokens_due[tokens_due.size()-1].last = 1;
  endtask

  task automatic send(logic [1:0] op, logic [7:0] c, logic [7:0] st, logic [3:0] sl,
                      logic [7:0] tg, logic [7:0] lb, logic [7:0] id, logic [4:0] cn);
    while ($urandom_range(99) < send_idle) begin
      push <= 0;
      @(posedge clk);
    end
    push <= 1;
    operation <= op;
    character <= c;
    state_index <= st;
    edge_slot <= sl;
    target_state <= tg;
    edge_label <= lb;
    token_id <= id;
    edge_count <= cn;
    @(posedge clk);
    while (full) @(posedge clk);
    n_items++;
    case (op)
      dct_pkg::OP_SCAN: lex_char(c);
      dct_pkg::OP_EDGE: begin
        lex_tgt[st*NEDGE+sl] = tg;
        lex_lbl[st*NEDGE+sl] = lb;
        written[st*NEDGE+sl] = 1;
      end
      dct_pkg::OP_ACCEPT: lex_acc[st] = id;
      default: lex_cnt[st] = cn > 16 ? 5'd16 : cn;
    endcase
  endtask

  task automatic scan_char(logic [7:0] c);
    send(dct_pkg::OP_SCAN, c, 8'($urandom), 4'($urandom), 8'($urandom), 8'($urandom),
         8'($urandom), 5'($urandom));
  endtask

  task automatic put_edge(logic [7:0] st, logic [3:0] sl, logic [7:0] tg, logic [7:0] lb);
    send(dct_pkg::OP_EDGE, 8'($urandom), st, sl, tg, lb, 8'($urandom), 5'($urandom));
  endtask

  task automatic put_accept(logic [7:0] st, logic [7:0] id);
    send(dct_pkg::OP_ACCEPT, 8'($urandom), st, 4'($urandom), 8'($urandom), 8'($urandom),
         id, 5'($urandom));
  endtask

  task automatic put_count(logic [7:0] st, int cn);
    // only expose written edges
    int ok;
    ok = 0;
    while (ok < cn && ok < 16 && written[st*NEDGE+ok]) ok++;
    if (cn > 16 && ok == 16) ok = cn;
    send(dct_pkg::OP_COUNT, 8'($urandom), st, 4'($urandom), 8'($urandom), 8'($urandom),
         8'($urandom), 5'(ok));
  endtask

  task automatic drain();
    push <= 0;
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // identifiers (1), numbers (2), spaces (3), quoted string (4)
  task automatic load_grammar();
    put_edge(0, 0, 1, -8'sd4);
    put_edge(0, 1, 2, -8'sd5);
    put_edge(0, 2, 3, -8'sd7);
    put_edge(0, 3, 4, dct_pkg::CH_DQUOTE);
    put_edge(1, 0, 1, -8'sd6);
    put_edge(2, 0, 2, -8'sd5);
    put_edge(3, 0, 3, -8'sd7);
    put_edge(4, 0, 5, dct_pkg::CH_DQUOTE);
    put_edge(4, 1, 4, -8'sd1);
    put_count(0, 4);
    put_count(1, 1);
    put_count(2, 1);
    put_count(3, 1);
    put_count(4, 2);
    put_accept(1, 1);
    put_accept(2, 2);
    put_accept(3, 3);
    put_accept(5, 4);
  endtask

  task automatic test_directed();
    load_grammar();
    scan_char("a"); scan_char("Z"); scan_char("9"); scan_char(dct_pkg::CH_SPACE);
    scan_char("7"); scan_char(dct_pkg::CH_DQUOTE); scan_char("q");
    scan_char(dct_pkg::CH_SQUOTE);
    scan_char(dct_pkg::CH_DQUOTE); scan_char(dct_pkg::CH_EOL);
    scan_char(8'hff); scan_char("x"); scan_char(dct_pkg::CH_EOL);
    scan_char(dct_pkg::CH_DQUOTE); scan_char("a"); scan_char(dct_pkg::CH_EOL);
    scan_char(dct_pkg::CH_TAB); scan_char(dct_pkg::CH_EOL); scan_char(dct_pkg::CH_EOL);
    drain();
  endtask

  task automatic test_all_classes();
    for (int k = 1; k <= 10; k++) put_edge(8'd6, 4'(k - 1), 8'd7, 8'(-k));
    put_edge(6, 10, 7, 8'sd127);
    put_edge(6, 11, 7, -8'sd128);
    put_edge(7, 0, 6, -8'sd1);
    put_accept(7, 255);
    put_count(6, 12);
    put_count(7, 1);
    put_edge(0, 4, 6, dct_pkg::CH_NEWLINE);
    put_count(0, 5);
    scan_char(dct_pkg::CH_NEWLINE); scan_char(dct_pkg::CH_TAB);
    scan_char(dct_pkg::CH_NEWLINE);
    scan_char(8'd127); scan_char(8'd128); scan_char(dct_pkg::CH_EOL);
    drain();
  endtask

  task automatic test_random_lines(int n);
    logic [7:0] pool[16];
    pool = '{"a", "Q", "z", "0", "9", dct_pkg::CH_SPACE, dct_pkg::CH_DQUOTE,
             dct_pkg::CH_SQUOTE, dct_pkg::CH_TAB, dct_pkg::CH_NEWLINE,
             8'd127, 8'd1, "_", 8'd200, dct_pkg::CH_EOL, dct_pkg::CH_EOL};
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 8) scan_char(pool[$urandom_range(15)]);
      else scan_char(8'($urandom));
    end
    scan_char(dct_pkg::CH_EOL);
    drain();
  endtask

  task automatic test_random_table();
    int st, sl;
    for (int i = 0; i < 40; i++) begin
      st = $urandom_range(15);
      sl = $urandom_range(15);
      put_edge(8'(st), 4'(sl),
               $urandom_range(9) == 0 ? 8'($urandom) : 8'($urandom_range(15)),
               $urandom_range(1) ? 8'($urandom_range(127)) : 8'(-$urandom_range(12)));
      if ($urandom_range(2) == 0)
        put_accept(8'(st), $urandom_range(3) == 0 ? 8'd0 : 8'($urandom));
      if ($urandom_range(2) == 0) put_count(8'(st), $urandom_range(17) + 1);
    end
    put_edge(255, 15, 0, 8'($urandom));
    put_accept(255, 8'hff);
    put_count(255, 31);
    drain();
  endtask

  task automatic test_long_token();
    put_edge(8, 0, 8, "L");
    put_count(8, 1);
    put_accept(8, 9);
    put_edge(0, 5, 8, "L");
    put_count(0, 6);
    send_idle = 0;
    for (int i = 0; i < 200; i++) scan_char("L");
    scan_char(dct_pkg::CH_EOL);
    drain();
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      n_results++;
      if (tokens_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transaction: kind %0d id %0d len %0d",
                                   kind, found_id, token_length);
      end else begin
        dct_pkg::result_t e;
        e = tokens_due.pop_front();
        if (e.kind == dct_pkg::KIND_TOKEN) n_tokens++; else n_lexerr++;
        if (kind !== e.kind || found_id !== e.found_id ||
            token_length !== e.token_length || last !== e.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp k%0d id%0d len%0d l%0d, got k%0d id%0d len%0d l%0d",
                     e.kind, e.found_id, e.token_length, e.last,
                     kind, found_id, token_length, last);
        end
      end
    end
    pop <= ($urandom_range(99) >= recv_idle);
  end

  initial begin
    for (int i = 0; i < NST*NEDGE; i++) begin
      lex_tgt[i] = 0; lex_lbl[i] = 0; written[i] = 0;
    end
    for (int i = 0; i < NST; i++) begin
      lex_cnt[i] = 0; lex_acc[i] = 0;
    end
    restart_token();
    dropping = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_all_classes();
    test_random_table();
    test_random_lines(320);
    send_idle = 49; recv_idle = 21;
    test_random_table();
    test_random_lines(320);
    send_idle = 0; recv_idle = 0;
    test_random_lines(300);
    test_long_token();
    $display("%0d items sent, %0d results checked (%0d tokens, %0d lexical errors)",
             n_items, n_results, n_tokens, n_lexerr);
    $display("covered table loads, every class label, random lines and a long token");
    if (errors == 0 && tokens_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d left over", errors, tokens_due.size());
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

@@ dfa_char_class_tokenizer.f @@
hdl/dct_pkg.sv
hdl/dct_front.sv
hdl/dct_res_queue.sv
hdl/dct_engine.sv
hdl/dfa_char_class_tokenizer.sv
tb/dfa_char_class_tokenizer_tb.sv
